[src/sdspi_pkg.sv]
// ----------------------------------------------------------------------------
// SD SPI host engine package
// Shared types, codes and constants of the SPI-mode card host engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int BLOCK_BYTES_DEF = 512;

    // Input function codes.
    typedef enum logic [1:0] {
        F_INIT = 2'd0,
        F_READ = 2'd1,
        F_BYTE = 2'd2,
        F_NONE = 2'd3
    } t_func;

    // Result kinds.
    typedef enum logic [1:0] {
        K_XFER = 2'd0,
        K_DATA = 2'd1,
        K_DONE = 2'd2,
        K_RSVD = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic [2:0] REG_RESP_TRIES = 3'd0;
    localparam logic [2:0] REG_TOKEN_TRIES = 3'd1;
    localparam logic [2:0] REG_SDV2_TRIES = 3'd2;
    localparam logic [2:0] REG_SDV1_TRIES = 3'd3;
    localparam logic [2:0] REG_DUMMY_BYTES = 3'd4;

    // Engine phases.
    typedef enum logic [3:0] {
        P_IDLE, P_DUMMY, P_DESEL, P_SEL, P_PKT, P_POLL, P_R7, P_OCR,
        P_TOKEN, P_LEAD, P_DATA, P_TRAIL, P_REL_INIT, P_REL_OK, P_REL_ERR
    } t_phase;

    // Command codes (bit 7 marks an application command).
    localparam logic [7:0] C_GO_IDLE = 8'h40;
    localparam logic [7:0] C_OP_MMC = 8'h41;
    localparam logic [7:0] C_IF_COND = 8'h48;
    localparam logic [7:0] C_BLOCKLEN = 8'h50;
    localparam logic [7:0] C_READ = 8'h51;
    localparam logic [7:0] C_APP = 8'h77;
    localparam logic [7:0] C_OCR = 8'h7A;
    localparam logic [7:0] C_APP_OP = 8'hE9;
    localparam logic [31:0] HCS_ARG = 32'h4000_0000;
    localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
    localparam logic [7:0] CRC_GO_IDLE = 8'h95;
    localparam logic [7:0] CRC_IF_COND = 8'h87;
    localparam logic [7:0] TOKEN_START = 8'hFE;

    // Card kinds.
    localparam logic [2:0] CARD_NONE = 3'd0;
    localparam logic [2:0] CARD_MMC = 3'd1;
    localparam logic [2:0] CARD_SDV1 = 3'd2;
    localparam logic [2:0] CARD_SDV2 = 3'd3;
    localparam logic [2:0] CARD_SDV2B = 3'd4;

    // Classified request passed from front to back.
    typedef struct packed {
        t_func       func;
        logic        bad;
        logic [31:0] sector;
        logic [8:0]  offset;
        logic [9:0]  count;
        logic [7:0]  rx_byte;
    } t_cmd;

    // One result item.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] tx_byte;
        logic       chip_select;
        logic [7:0] data_byte;
        logic       last;
        logic       status;
        logic [2:0] card_kind;
    } t_res;

endpackage

[src/sdspi_if.sv]
// ----------------------------------------------------------------------------
// SD SPI stream interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface sdspi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] sector;
    logic [8:0]  offset;
    logic [9:0]  count;
    logic [7:0]  rx_byte;
    modport source (output valid, func, sector, offset, count, rx_byte, input ready);
    modport sink (input valid, func, sector, offset, count, rx_byte, output ready);
endinterface

interface sdspi_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic [7:0] data_byte;
    logic       last;
    logic       status;
    logic [2:0] card_kind;
    modport source (output valid, kind, tx_byte, chip_select, data_byte, last, status,
                    card_kind, input ready);
    modport sink (input valid, kind, tx_byte, chip_select, data_byte, last, status,
                  card_kind, output ready);
endinterface

[src/sdspi_front.sv]
// ----------------------------------------------------------------------------
// SD SPI front end
// Accepts requests, checks read bounds and queues them for the engine.
// ----------------------------------------------------------------------------
module sdspi_front #(
    parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sdspi_in_if.sink          in_ch,
    output sdspi_pkg::t_cmd   o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready
);
    import sdspi_pkg::*;

    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd n_cmd;
    logic push, pop;

    // Classify the incoming request.
    always_comb begin
        n_cmd.func    = t_func'(in_ch.func);
        n_cmd.sector  = in_ch.sector;
        n_cmd.offset  = in_ch.offset;
        n_cmd.count   = in_ch.count;
        n_cmd.rx_byte = in_ch.rx_byte;
        n_cmd.bad     = (in_ch.count == '0) ||
                        ({2'b0, in_ch.offset} + {1'b0, in_ch.count} > 11'(BLOCK_BYTES));
    end

    assign in_ch.ready = (r_cnt != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop = o_cmd_valid && i_cmd_ready;
    assign o_cmd = r_q[r_rp];

    // Two-entry queue.
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !in_ch.ready) else $error("accept while full");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp) else $error("pointer skew");
endmodule

[src/sdspi_back.sv]
// ----------------------------------------------------------------------------
// SD SPI back end
// Runs the card protocol state machine, one request per cycle while its
// four-entry result buffer has room for two more; up to two results per request.
// ----------------------------------------------------------------------------
module sdspi_back #(
    parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sdspi_pkg::t_cmd  i_cmd,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  logic [7:0]       i_resp_tries,
    input  logic [15:0]      i_token_tries,
    input  logic [15:0]      i_sdv2_tries,
    input  logic [15:0]      i_sdv1_tries,
    input  logic [7:0]       i_dummy_bytes,
    sdspi_out_if.source      out_ch
);
    import sdspi_pkg::*;

    localparam int CW = $clog2(BLOCK_BYTES + 3);

    t_phase r_phase, n_phase;
    logic [2:0]  r_card, n_card;
    logic [7:0]  r_cur, n_cur;
    logic [31:0] r_arg, n_arg, r_ocr, n_ocr;
    logic [2:0]  r_pidx, n_pidx;
    logic [15:0] r_retry, n_retry;
    logic [CW-1:0] r_bcnt, n_bcnt, r_skip, n_skip, r_want, n_want;
    logic r_app, n_app;

    // Result buffer.
    t_res r_ob [4];
    logic [1:0] r_owp, r_orp;
    logic [2:0] r_ocnt;
    t_res res0, res1;
    logic [1:0] nres;
    logic go, pop;

    assign o_cmd_ready = (r_ocnt <= 3'd2);
    assign go = i_cmd_valid && o_cmd_ready;

    function automatic t_res mk_x(input logic [7:0] tx, input logic cs);
        t_res r;
        r = '0; r.kind = K_XFER; r.tx_byte = tx; r.chip_select = cs;
        return r;
    endfunction

    function automatic t_res mk_done(input logic st, input logic [2:0] ck);
        t_res r;
        r = '0; r.kind = K_DONE; r.status = st; r.card_kind = ck;
        return r;
    endfunction

    // Next state and results of one request.
    always_comb begin
        logic [7:0] eff, rx, pb, res;
        logic [31:0] a, o;
        logic hold;
        logic [15:0] rc;
        n_phase = r_phase; n_card = r_card; n_cur = r_cur; n_arg = r_arg;
        n_ocr = r_ocr; n_pidx = r_pidx; n_retry = r_retry; n_bcnt = r_bcnt;
        n_skip = r_skip; n_want = r_want; n_app = r_app;
        res0 = '0; res1 = '0; nres = 2'd0;
        rx = i_cmd.rx_byte; res = rx; hold = 1'b0; rc = r_retry;
        eff = r_app ? C_APP : {1'b0, r_cur[6:0]};
        a = r_app ? 32'd0 : r_arg;
        unique case (r_pidx)
            3'd0: pb = eff;
            3'd1: pb = a[31:24];
            3'd2: pb = a[23:16];
            3'd3: pb = a[15:8];
            3'd4: pb = a[7:0];
            default: pb = (eff == C_GO_IDLE) ? CRC_GO_IDLE :
                          (eff == C_IF_COND) ? CRC_IF_COND : 8'h01;
        endcase
        o = {r_ocr[23:0], rx};
        unique case (i_cmd.func)
            F_INIT: if (r_phase == P_IDLE) begin
                n_card = CARD_NONE;
                nres = 2'd1; res0 = mk_x(8'hFF, 1'b0);
                if (i_dummy_bytes == 8'd0) begin
                    n_cur = C_GO_IDLE; n_arg = '0; n_app = 1'b0; n_phase = P_DESEL;
                end else begin
                    n_retry = {8'd0, i_dummy_bytes}; n_phase = P_DUMMY;
                end
            end
            F_READ: if (r_phase == P_IDLE) begin
                nres = 2'd1;
                if (i_cmd.bad) begin
                    res0 = mk_done(1'b1, r_card);
                end else begin
                    res0 = mk_x(8'hFF, 1'b0);
                    n_skip = CW'(i_cmd.offset); n_want = CW'(i_cmd.count);
                    n_cur = C_READ; n_app = 1'b0; n_phase = P_DESEL;
                    n_arg = (r_card == CARD_SDV2B) ? i_cmd.sector :
                            i_cmd.sector * 32'(BLOCK_BYTES);
                end
            end
            F_BYTE: if (r_phase != P_IDLE) begin
                nres = 2'd1; res0 = mk_x(8'hFF, 1'b1);
                unique case (r_phase)
                    P_DUMMY: begin
                        n_retry = r_retry - 16'd1; res0.chip_select = 1'b0;
                        if (n_retry == 16'd0) begin
                            n_cur = C_GO_IDLE; n_arg = '0; n_app = 1'b0; n_phase = P_DESEL;
                        end
                    end
                    P_DESEL: n_phase = P_SEL;
                    P_SEL: begin
                        if (r_cur[7] && !r_app) begin
                            n_app = 1'b1; n_phase = P_DESEL; res0.chip_select = 1'b0;
                        end else begin
                            n_pidx = 3'd1; n_phase = P_PKT; res0.tx_byte = eff;
                        end
                    end
                    P_PKT: begin
                        if (r_pidx < 3'd6) begin
                            res0.tx_byte = pb; n_pidx = r_pidx + 3'd1;
                        end else begin
                            n_bcnt = CW'(i_resp_tries); n_phase = P_POLL;
                        end
                    end
                    P_POLL: begin
                        logic [7:0] bc;
                        logic cd;
                        bc = r_bcnt[7:0] - 8'd1;
                        cd = 1'b0;
                        if (rx[7]) begin
                            n_bcnt = CW'(bc);
                            if (bc != 8'd0) hold = 1'b1;
                        end
                        if (!hold) begin
                            if (r_app) begin
                                n_app = 1'b0;
                                if (rx > 8'd1) cd = 1'b1;
                                else begin
                                    n_pidx = 3'd1; n_phase = P_PKT;
                                    res0.tx_byte = {1'b0, r_cur[6:0]};
                                end
                            end else cd = 1'b1;
                        end
                        if (cd) begin
                            // Command completion.
                            res0.chip_select = 1'b0; n_phase = P_REL_INIT;
                            case (r_cur)
                                C_GO_IDLE: if (res == 8'd1) begin
                                    n_cur = C_IF_COND; n_arg = IF_COND_ARG; n_phase = P_DESEL;
                                end
                                C_IF_COND: begin
                                    if (res == 8'd1) begin
                                        n_pidx = '0; n_ocr = '0; n_phase = P_R7;
                                        res0.chip_select = 1'b1;
                                    end else begin
                                        n_cur = C_APP_OP; n_arg = '0; n_phase = P_DESEL;
                                    end
                                end
                                C_APP_OP: begin
                                    if (r_arg == HCS_ARG) begin
                                        if (res == 8'd0) begin
                                            n_cur = C_OCR; n_arg = '0; n_phase = P_DESEL;
                                        end else begin
                                            n_retry = r_retry - 16'd1;
                                            if (n_retry != 16'd0) begin
                                                n_arg = HCS_ARG; n_phase = P_DESEL;
                                            end
                                        end
                                    end else if (r_card == CARD_NONE ||
                                                 res != 8'd0) begin
                                        logic [2:0] ct;
                                        ct = r_card;
                                        if (r_card == CARD_NONE) begin
                                            ct = (res <= 8'd1) ? CARD_SDV2 - 3'd1 : CARD_MMC;
                                            rc = i_sdv1_tries;
                                        end else rc = r_retry - 16'd1;
                                        n_card = ct; n_retry = rc;
                                        if (rc == 16'd0) n_card = CARD_NONE;
                                        else begin
                                            n_cur = (ct == CARD_SDV1) ? C_APP_OP : C_OP_MMC;
                                            n_arg = '0; n_phase = P_DESEL;
                                        end
                                    end else begin
                                        n_cur = C_BLOCKLEN; n_arg = 32'(BLOCK_BYTES);
                                        n_phase = P_DESEL;
                                    end
                                end
                                C_OP_MMC: begin
                                    if (res == 8'd0) begin
                                        n_cur = C_BLOCKLEN; n_arg = 32'(BLOCK_BYTES);
                                        n_phase = P_DESEL;
                                    end else begin
                                        rc = r_retry - 16'd1; n_retry = rc;
                                        if (rc == 16'd0) n_card = CARD_NONE;
                                        else begin
                                            n_cur = (r_card == CARD_SDV1) ? C_APP_OP :
                                                    C_OP_MMC;
                                            n_arg = '0; n_phase = P_DESEL;
                                        end
                                    end
                                end
                                C_BLOCKLEN: if (res != 8'd0) n_card = CARD_NONE;
                                C_OCR: if (res == 8'd0) begin
                                    n_pidx = '0; n_ocr = '0; n_phase = P_OCR;
                                    res0.chip_select = 1'b1;
                                end
                                C_READ: begin
                                    if (res == 8'd0) begin
                                        n_retry = i_token_tries; n_phase = P_TOKEN;
                                        res0.chip_select = 1'b1;
                                    end else n_phase = P_REL_ERR;
                                end
                                default: n_card = CARD_NONE;
                            endcase
                            if (n_phase == P_DESEL && r_cur != C_READ) n_app = 1'b0;
                            if (n_phase == P_DESEL) n_app = 1'b0;
                        end
                    end
                    P_R7, P_OCR: begin
                        n_ocr = o; n_pidx = r_pidx + 3'd1;
                        if (r_pidx == 3'd3) begin
                            res0.chip_select = 1'b0; n_phase = P_REL_INIT;
                            if (r_phase == P_OCR) begin
                                n_card = o[30] ? CARD_SDV2B : CARD_SDV2;
                            end else if (o[15:0] == 16'h01AA) begin
                                n_retry = i_sdv2_tries;
                                if (i_sdv2_tries != 16'd0) begin
                                    n_cur = C_APP_OP; n_arg = HCS_ARG; n_app = 1'b0;
                                    n_phase = P_DESEL;
                                end
                            end
                        end
                    end
                    P_TOKEN: begin
                        if (rx == 8'hFF) begin
                            n_retry = r_retry - 16'd1;
                            if (n_retry != 16'd0) hold = 1'b1;
                        end
                        if (!hold) begin
                            if (rx != TOKEN_START) begin
                                res0.chip_select = 1'b0; n_phase = P_REL_ERR;
                            end else begin
                                n_bcnt = CW'(BLOCK_BYTES + 2) - r_skip - r_want;
                                n_phase = (r_skip != '0) ? P_LEAD : P_DATA;
                            end
                        end
                    end
                    P_LEAD: begin
                        n_skip = r_skip - CW'(1);
                        if (n_skip == '0) n_phase = P_DATA;
                    end
                    P_DATA: begin
                        nres = 2'd2; res1 = res0;
                        res0 = '0; res0.kind = K_DATA; res0.data_byte = rx;
                        res0.last = (r_want == CW'(1));
                        n_want = r_want - CW'(1);
                        if (n_want == '0) n_phase = P_TRAIL;
                    end
                    P_TRAIL: begin
                        n_bcnt = r_bcnt - CW'(1);
                        if (n_bcnt == '0) begin
                            res0.chip_select = 1'b0; n_phase = P_REL_OK;
                        end
                    end
                    P_REL_INIT: begin
                        n_phase = P_IDLE; res0 = mk_done(r_card == CARD_NONE, r_card);
                    end
                    P_REL_OK, P_REL_ERR: begin
                        n_phase = P_IDLE; res0 = mk_done(r_phase == P_REL_ERR, r_card);
                    end
                    default: begin
                        n_phase = P_IDLE; nres = 2'd0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Phase register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
        end else if (go) begin
            r_phase <= n_phase;
        end
    end

    // Engine working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card <= '0; r_cur <= '0; r_arg <= '0; r_ocr <= '0; r_pidx <= '0;
            r_retry <= '0; r_bcnt <= '0; r_skip <= '0; r_want <= '0; r_app <= 1'b0;
        end else if (go) begin
            r_card <= n_card; r_cur <= n_cur; r_arg <= n_arg; r_ocr <= n_ocr;
            r_pidx <= n_pidx; r_retry <= n_retry; r_bcnt <= n_bcnt;
            r_skip <= n_skip; r_want <= n_want; r_app <= n_app;
        end
    end

    // Result buffer.
    assign pop = out_ch.valid && out_ch.ready;
    always_ff @(posedge i_clk) begin
        if (go && nres != 2'd0) r_ob[r_owp] <= res0;
        if (go && nres == 2'd2) r_ob[r_owp + 2'd1] <= res1;
        if (!i_rst_n) begin
            r_owp <= '0; r_orp <= '0; r_ocnt <= '0;
        end else begin
            if (go) r_owp <= r_owp + nres;
            if (pop) r_orp <= r_orp + 2'd1;
            r_ocnt <= r_ocnt + (go ? 3'(nres) : 3'd0) - 3'(pop);
        end
    end

    assign out_ch.valid       = (r_ocnt != 3'd0);
    assign out_ch.kind        = r_ob[r_orp].kind;
    assign out_ch.tx_byte     = r_ob[r_orp].tx_byte;
    assign out_ch.chip_select = r_ob[r_orp].chip_select;
    assign out_ch.data_byte   = r_ob[r_orp].data_byte;
    assign out_ch.last        = r_ob[r_orp].last;
    assign out_ch.status      = r_ob[r_orp].status;
    assign out_ch.card_kind   = r_ob[r_orp].card_kind;

    a_ocnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_ocnt <= 3'd4)
        else $error("result buffer overflow");
    a_card: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_card <= CARD_SDV2B)
        else $error("bad card kind");
    a_pidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == P_PKT |-> r_pidx != 3'd0) else $error("packet index lost");
endmodule

[src/sd_card_spi_host_engine.sv]
// ----------------------------------------------------------------------------
// SD card SPI host engine
// Top level: configuration registers, request front end and protocol engine.
// ----------------------------------------------------------------------------
// Each request (init, read, or a received SPI byte) is accepted while the
// request queue has room and produces up to two results. A two-entry
// request queue and a four-entry result buffer decouple the sides; the
// engine takes one request per cycle while the buffer has room for two more
// results. Every transfer result must be answered by a byte-received request
// carrying the MISO byte.
module sd_card_spi_host_engine #(
    parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    sdspi_in_if.sink    in_ch,
    sdspi_out_if.source out_ch
);
    import sdspi_pkg::*;

    logic [7:0]  r_resp, r_dummy;
    logic [15:0] r_token, r_sdv2, r_sdv1;
    t_cmd cmd;
    logic cmd_valid, cmd_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp <= 8'd10; r_token <= 16'd30000; r_sdv2 <= 16'd12000;
            r_sdv1 <= 16'd25000; r_dummy <= 8'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RESP_TRIES:  r_resp <= i_cfg_data[7:0];
                REG_TOKEN_TRIES: r_token <= i_cfg_data;
                REG_SDV2_TRIES:  r_sdv2 <= i_cfg_data;
                REG_SDV1_TRIES:  r_sdv1 <= i_cfg_data;
                REG_DUMMY_BYTES: r_dummy <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    sdspi_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
        .i_clk, .i_rst_n, .in_ch, .o_cmd(cmd), .o_cmd_valid(cmd_valid),
        .i_cmd_ready(cmd_ready)
    );

    sdspi_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_resp_tries(r_resp), .i_token_tries(r_token), .i_sdv2_tries(r_sdv2),
        .i_sdv1_tries(r_sdv1), .i_dummy_bytes(r_dummy), .out_ch
    );
endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// SD card SPI host engine testbench
// Drives init and partial sector read requests into the engine and answers
// every SPI transfer with a byte from a simple behavioral card. A built-in
// predictor tracks the engine state and supplies the expected results, which
// are checked field by field as they come out under random idling.
// ----------------------------------------------------------------------------
module tb;
    import sdspi_pkg::*;

    // Behavioral card personalities.
    localparam int PROF_SDV2 = 0;
    localparam int PROF_SDV1 = 1;
    localparam int PROF_MMC = 2;
    localparam int PROF_NOISE = 3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    sdspi_in_if  req_if ();
    sdspi_out_if res_if ();

    sd_card_spi_host_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (req_if),
        .out_ch     (res_if)
    );

    // Clock generation.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Shadow registers and engine state of the predictor.
    logic [7:0]  pr_resp_tries;
    logic [15:0] pr_token_tries;
    logic [15:0] pr_v2_tries;
    logic [15:0] pr_v1_tries;
    logic [7:0]  pr_dummy;

    t_phase      pr_phase;
    logic [2:0]  pr_card;
    logic [7:0]  pr_cmd;
    logic [31:0] pr_arg;
    logic [7:0]  pr_pidx;
    logic [15:0] pr_retry;
    logic [15:0] pr_bcnt;
    logic [15:0] pr_skip;
    logic [15:0] pr_want;
    logic [31:0] pr_ocr;
    logic        pr_app;

    t_res expected_results[$];

    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int card_profile = PROF_SDV2;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit out_taken;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic emit(t_kind k, logic [7:0] tx, logic cs, logic [7:0] d, logic lst,
                        logic st, logic [2:0] ck);
        t_res r;
        r.kind = k;
        r.tx_byte = tx;
        r.chip_select = cs;
        r.data_byte = d;
        r.last = lst;
        r.status = st;
        r.card_kind = ck;
        expected_results.push_back(r);
    endtask

    task automatic spi_xfer(logic [7:0] tx, logic cs);
        emit(K_XFER, tx, cs, 8'h00, 1'b0, 1'b0, 3'd0);
    endtask

    task automatic begin_cmd(logic [7:0] c, logic [31:0] a);
        pr_cmd = c;
        pr_arg = a;
        pr_app = 1'b0;
        pr_phase = P_DESEL;
        spi_xfer(8'hFF, 1'b0);
    endtask

    task automatic release_to(t_phase p);
        pr_phase = p;
        spi_xfer(8'hFF, 1'b0);
    endtask

    function automatic logic [7:0] frame_byte(logic [7:0] i);
        logic [7:0]  eff;
        logic [31:0] a;
        eff = pr_app ? C_APP : {1'b0, pr_cmd[6:0]};
        a = pr_app ? 32'd0 : pr_arg;
        if (i == 0) return eff;
        if (i <= 4) return 8'(a >> (8 * (4 - i)));
        if (eff == C_GO_IDLE) return CRC_GO_IDLE;
        if (eff == C_IF_COND) return CRC_IF_COND;
        return 8'h01;
    endfunction

    task automatic send_frame_byte();
        spi_xfer(frame_byte(pr_pidx), 1'b1);
        pr_pidx = pr_pidx + 8'd1;
        pr_phase = P_PKT;
    endtask

    task automatic start_four(t_phase p);
        pr_pidx = 0;
        pr_ocr = 0;
        pr_phase = p;
        spi_xfer(8'hFF, 1'b1);
    endtask

    task automatic v1_retry_or_fail();
        if (pr_retry == 0) begin
            pr_card = CARD_NONE;
            release_to(P_REL_INIT);
        end else begin
            begin_cmd(pr_card == CARD_SDV1 ? C_APP_OP : C_OP_MMC, 32'd0);
        end
    endtask

    task automatic response_done(logic [7:0] res);
        case (pr_cmd)
            C_GO_IDLE: begin
                if (res == 1) begin_cmd(C_IF_COND, IF_COND_ARG);
                else release_to(P_REL_INIT);
            end
            C_IF_COND: begin
                if (res == 1) start_four(P_R7);
                else begin_cmd(C_APP_OP, 32'd0);
            end
            C_APP_OP: begin
                if (pr_arg == HCS_ARG) begin
                    if (res == 0) begin
                        begin_cmd(C_OCR, 32'd0);
                    end else begin
                        pr_retry = pr_retry - 16'd1;
                        if (pr_retry == 0) release_to(P_REL_INIT);
                        else begin_cmd(C_APP_OP, HCS_ARG);
                    end
                end else if (pr_card == CARD_NONE) begin
                    pr_card = (res <= 1) ? CARD_SDV1 : CARD_MMC;
                    pr_retry = pr_v1_tries;
                    v1_retry_or_fail();
                end else if (res == 0) begin
                    begin_cmd(C_BLOCKLEN, 32'd512);
                end else begin
                    pr_retry = pr_retry - 16'd1;
                    v1_retry_or_fail();
                end
            end
            C_OP_MMC: begin
                if (res == 0) begin
                    begin_cmd(C_BLOCKLEN, 32'd512);
                end else begin
                    pr_retry = pr_retry - 16'd1;
                    v1_retry_or_fail();
                end
            end
            C_BLOCKLEN: begin
                if (res != 0) pr_card = CARD_NONE;
                release_to(P_REL_INIT);
            end
            C_OCR: begin
                if (res == 0) start_four(P_OCR);
                else release_to(P_REL_INIT);
            end
            C_READ: begin
                if (res == 0) begin
                    pr_retry = pr_token_tries;
                    pr_phase = P_TOKEN;
                    spi_xfer(8'hFF, 1'b1);
                end else begin
                    release_to(P_REL_ERR);
                end
            end
            default: begin
                pr_card = CARD_NONE;
                release_to(P_REL_INIT);
            end
        endcase
    endtask

    task automatic byte_received(logic [7:0] rx);
        case (pr_phase)
            P_DUMMY: begin
                pr_retry = pr_retry - 16'd1;
                if (pr_retry == 0) begin_cmd(C_GO_IDLE, 32'd0);
                else spi_xfer(8'hFF, 1'b0);
            end
            P_DESEL: begin
                pr_phase = P_SEL;
                spi_xfer(8'hFF, 1'b1);
            end
            P_SEL: begin
                if (pr_cmd[7] && !pr_app) begin
                    pr_app = 1'b1;
                    pr_phase = P_DESEL;
                    spi_xfer(8'hFF, 1'b0);
                end else begin
                    pr_pidx = 0;
                    send_frame_byte();
                end
            end
            P_PKT: begin
                if (pr_pidx < 6) begin
                    send_frame_byte();
                end else begin
                    pr_bcnt = {8'd0, pr_resp_tries};
                    pr_phase = P_POLL;
                    spi_xfer(8'hFF, 1'b1);
                end
            end
            P_POLL: begin
                if (rx[7]) pr_bcnt = (pr_bcnt - 16'd1) & 16'h00FF;
                if (rx[7] && pr_bcnt != 0) begin
                    spi_xfer(8'hFF, 1'b1);
                end else if (pr_app) begin
                    pr_app = 1'b0;
                    if (rx > 1) begin
                        response_done(rx);
                    end else begin
                        pr_pidx = 0;
                        send_frame_byte();
                    end
                end else begin
                    response_done(rx);
                end
            end
            P_R7, P_OCR: begin
                pr_ocr = {pr_ocr[23:0], rx};
                pr_pidx = pr_pidx + 8'd1;
                if (pr_pidx < 4) begin
                    spi_xfer(8'hFF, 1'b1);
                end else if (pr_phase == P_OCR) begin
                    pr_card = pr_ocr[30] ? CARD_SDV2B : CARD_SDV2;
                    release_to(P_REL_INIT);
                end else if (pr_ocr[15:0] == IF_COND_ARG[15:0]) begin
                    pr_retry = pr_v2_tries;
                    if (pr_retry == 0) release_to(P_REL_INIT);
                    else begin_cmd(C_APP_OP, HCS_ARG);
                end else begin
                    release_to(P_REL_INIT);
                end
            end
            P_TOKEN: begin
                if (rx == 8'hFF) pr_retry = pr_retry - 16'd1;
                if (rx == 8'hFF && pr_retry != 0) begin
                    spi_xfer(8'hFF, 1'b1);
                end else if (rx != TOKEN_START) begin
                    release_to(P_REL_ERR);
                end else begin
                    pr_bcnt = 16'd514 - pr_skip - pr_want;
                    pr_phase = (pr_skip != 0) ? P_LEAD : P_DATA;
                    spi_xfer(8'hFF, 1'b1);
                end
            end
            P_LEAD: begin
                pr_skip = pr_skip - 16'd1;
                if (pr_skip == 0) pr_phase = P_DATA;
                spi_xfer(8'hFF, 1'b1);
            end
            P_DATA: begin
                emit(K_DATA, 8'h00, 1'b0, rx, pr_want == 1, 1'b0, 3'd0);
                pr_want = pr_want - 16'd1;
                if (pr_want == 0) pr_phase = P_TRAIL;
                spi_xfer(8'hFF, 1'b1);
            end
            P_TRAIL: begin
                pr_bcnt = pr_bcnt - 16'd1;
                if (pr_bcnt == 0) release_to(P_REL_OK);
                else spi_xfer(8'hFF, 1'b1);
            end
            P_REL_INIT: begin
                pr_phase = P_IDLE;
                emit(K_DONE, 8'h00, 1'b0, 8'h00, 1'b0, pr_card == CARD_NONE, pr_card);
            end
            P_REL_OK, P_REL_ERR: begin
                emit(K_DONE, 8'h00, 1'b0, 8'h00, 1'b0, pr_phase == P_REL_ERR, pr_card);
                pr_phase = P_IDLE;
            end
            default: pr_phase = P_IDLE;
        endcase
    endtask

    // Advance the predictor by one accepted request.
    task automatic predict_request(t_func f, logic [31:0] sec, logic [8:0] off,
                                   logic [9:0] cnt, logic [7:0] rx);
        case (f)
            F_BYTE: if (pr_phase != P_IDLE) byte_received(rx);
            F_INIT: begin
                if (pr_phase == P_IDLE) begin
                    pr_card = CARD_NONE;
                    if (pr_dummy == 0) begin
                        begin_cmd(C_GO_IDLE, 32'd0);
                    end else begin
                        pr_retry = {8'd0, pr_dummy};
                        pr_phase = P_DUMMY;
                        spi_xfer(8'hFF, 1'b0);
                    end
                end
            end
            F_READ: begin
                if (pr_phase == P_IDLE) begin
                    if (cnt == 0 || 32'(off) + 32'(cnt) > 32'd512) begin
                        emit(K_DONE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, pr_card);
                    end else begin
                        pr_skip = 16'(off);
                        pr_want = 16'(cnt);
                        begin_cmd(C_READ, (pr_card != CARD_SDV2B) ? (sec << 9) : sec);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Behavioral card: picks the MISO byte from the engine's current phase.
    // ------------------------------------------------------------------
    function automatic logic [7:0] card_reply();
        int roll;
        roll = $urandom_range(99);
        if (card_profile == PROF_NOISE) return 8'($urandom);
        case (pr_phase)
            P_POLL: begin
                if (roll < 20) return 8'($urandom) | 8'h80;
                if (pr_app) return (roll < 25) ? 8'h05 : 8'h01;
                case (pr_cmd)
                    C_GO_IDLE: return (roll < 24) ? 8'($urandom_range(2, 127)) : 8'h01;
                    C_IF_COND: return (card_profile == PROF_SDV2) ? 8'h01 : 8'h05;
                    C_APP_OP: begin
                        if (card_profile == PROF_MMC) return 8'h05;
                        return (roll < 60) ? 8'h01 : 8'h00;
                    end
                    C_OP_MMC: return (roll < 60) ? 8'h01 : 8'h00;
                    C_BLOCKLEN, C_READ: return (roll < 30) ? 8'h04 : 8'h00;
                    default: return 8'h00;
                endcase
            end
            P_R7: begin
                if (roll < 5) return 8'($urandom);
                case (pr_pidx)
                    8'd2: return 8'h01;
                    8'd3: return 8'hAA;
                    default: return 8'h00;
                endcase
            end
            P_TOKEN: begin
                if (roll < 60) return 8'hFF;
                if (roll < 95) return TOKEN_START;
                return 8'($urandom);
            end
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Send one request; the predictor advances once the engine takes it.
    task automatic send_request(t_func f, logic [31:0] sec, logic [8:0] off,
                                logic [9:0] cnt, logic [7:0] rx);
        while ($urandom_range(99) < idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.func <= f;
        req_if.sector <= sec;
        req_if.offset <= off;
        req_if.count <= cnt;
        req_if.rx_byte <= rx;
        forever begin
            @(negedge i_clk);
            if (req_if.ready) break;
        end
        predict_request(f, sec, off, cnt, rx);
        items_sent++;
        @(posedge i_clk);
    endtask

    task automatic stop_sending();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Run one request to completion, answering every SPI transfer.
    task automatic run_request(t_func f, logic [31:0] sec, logic [8:0] off, logic [9:0] cnt);
        int roll;
        send_request(f, sec, off, cnt, 8'($urandom));
        while (pr_phase != P_IDLE) begin
            roll = $urandom_range(99);
            if (roll < 2) send_request(F_NONE, $urandom, 9'($urandom), 10'($urandom), 8'($urandom));
            else if (roll < 4)
                send_request(t_func'($urandom_range(0, 1)), $urandom, 9'($urandom),
                             10'($urandom), 8'($urandom));
            else send_request(F_BYTE, $urandom, 9'($urandom), 10'($urandom), card_reply());
        end
    endtask

    // Wait until every expected result has come out and the engine settled.
    task automatic wait_drained();
        stop_sending();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_RESP_TRIES: pr_resp_tries = value[7:0];
            REG_TOKEN_TRIES: pr_token_tries = value;
            REG_SDV2_TRIES: pr_v2_tries = value;
            REG_SDV1_TRIES: pr_v1_tries = value;
            REG_DUMMY_BYTES: pr_dummy = value[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] resp, logic [15:0] tok, logic [15:0] v2,
                             logic [15:0] v1, logic [15:0] dummy);
        wait_drained();
        write_reg(REG_RESP_TRIES, resp);
        write_reg(REG_TOKEN_TRIES, tok);
        write_reg(REG_SDV2_TRIES, v2);
        write_reg(REG_SDV1_TRIES, v1);
        write_reg(REG_DUMMY_BYTES, dummy);
    endtask

    task automatic random_read();
        int roll;
        logic [8:0] off;
        logic [9:0] cnt;
        roll = $urandom_range(99);
        off = 9'($urandom_range(0, 511));
        if (roll < 15) begin
            cnt = (roll < 5) ? 10'd0 : 10'(512 - off + $urandom_range(1, 300));
        end else begin
            cnt = 10'($urandom_range(1, 16));
            if (32'(off) + 32'(cnt) > 512) off = 9'(512 - cnt);
        end
        run_request(F_READ, $urandom, off, cnt);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Directed corner cases: bad reads, unknown and stray requests and the
    // SDv2, SDv1 and MMC card profiles.
    task automatic test_directed();
        write_all(16'd255, 16'd65535, 16'd65535, 16'd65535, 16'd1);
        run_request(F_READ, 32'hFFFF_FFFF, 9'd0, 10'd0);
        run_request(F_READ, 32'd0, 9'd511, 10'd2);
        send_request(F_BYTE, 32'd0, 9'd0, 10'd0, 8'hFF);
        send_request(F_NONE, 32'hFFFF_FFFF, 9'd511, 10'd1023, 8'h00);
        card_profile = PROF_SDV2;
        run_request(F_INIT, 32'd0, 9'd0, 10'd0);
        card_profile = PROF_SDV1;
        run_request(F_INIT, 32'd0, 9'd0, 10'd0);
        card_profile = PROF_MMC;
        run_request(F_INIT, 32'd0, 9'd0, 10'd0);
    endtask

    // Zero settings: wrapped poll counts, init paths giving up at once, no
    // dummy clocks and a full sector read without a card.
    task automatic test_zero_settings();
        write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        card_profile = PROF_SDV2;
        run_request(F_INIT, 32'd0, 9'd0, 10'd0);
        card_profile = PROF_SDV1;
        run_request(F_INIT, 32'd0, 9'd0, 10'd0);
        run_request(F_READ, 32'd7, 9'd0, 10'd512);
        write_all(16'd1, 16'd1, 16'd1, 16'd1, 16'd255);
        card_profile = PROF_MMC;
        run_request(F_INIT, 32'd0, 9'd0, 10'd0);
    endtask

    // Random requests against random card kinds until enough items are sent.
    task automatic test_random(int target);
        int roll;
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                card_profile = (roll < 4) ? PROF_NOISE : $urandom_range(PROF_SDV2, PROF_MMC);
                run_request(F_INIT, $urandom, 9'($urandom), 10'($urandom));
            end else if (roll < 75) begin
                random_read();
            end else begin
                send_request(roll[0] ? F_NONE : F_BYTE, $urandom, 9'($urandom),
                             10'($urandom), 8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(negedge i_clk) begin
        t_res want;
        out_taken = res_if.valid && res_if.ready;
        if (i_rst_n && out_taken) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d tx %02h", $time, res_if.kind,
                         res_if.tx_byte);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (res_if.kind !== want.kind || res_if.tx_byte !== want.tx_byte ||
                    res_if.chip_select !== want.chip_select ||
                    res_if.data_byte !== want.data_byte || res_if.last !== want.last ||
                    res_if.status !== want.status || res_if.card_kind !== want.card_kind) begin
                    $display("%0t: mismatch expected kind %0d tx %02h cs %0d data %02h",
                             $time, want.kind, want.tx_byte, want.chip_select, want.data_byte);
                    $display("    last %0d status %0d card %0d; actual kind %0d tx %02h",
                             want.last, want.status, want.card_kind, res_if.kind,
                             res_if.tx_byte);
                    $display("    cs %0d data %02h last %0d status %0d card %0d",
                             res_if.chip_select, res_if.data_byte, res_if.last,
                             res_if.status, res_if.card_kind);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves anything.
    always @(negedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("sd_card_spi_host_engine test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_RESP_TRIES;
        i_cfg_data <= 16'd0;
        req_if.valid <= 1'b0;
        req_if.func <= F_NONE;
        req_if.sector <= 32'd0;
        req_if.offset <= 9'd0;
        req_if.count <= 10'd0;
        req_if.rx_byte <= 8'd0;
        pr_resp_tries = 8'd10;
        pr_token_tries = 16'd30000;
        pr_v2_tries = 16'd12000;
        pr_v1_tries = 16'd25000;
        pr_dummy = 8'd100;
        pr_phase = P_IDLE;
        pr_card = CARD_NONE;
        pr_cmd = 8'd0;
        pr_arg = 32'd0;
        pr_pidx = 8'd0;
        pr_retry = 16'd0;
        pr_bcnt = 16'd0;
        pr_skip = 16'd0;
        pr_want = 16'd0;
        pr_ocr = 32'd0;
        pr_app = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        idle_pct = 84;
        write_all(16'd3, 16'd200, 16'd40, 16'd40, 16'd8);
        test_random(150);
        idle_pct = 0;
        stall_pct = 84;
        test_zero_settings();
        idle_pct = 35;
        stall_pct = 35;
        write_all(16'd2, 16'd1000, 16'd100, 16'd100, 16'd1);
        test_random(150);

        wait_drained();
        if (errors == 0) begin
            $display("sd_card_spi_host_engine test passed");
        end else begin
            $display("sd_card_spi_host_engine test failed");
        end
        $finish;
    end
endmodule
